// ===== design/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared constants, token codes and word types of the postfix evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int ITER_W      = $clog2(DATA_W);

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

	localparam logic [2:0] KIND_NUM = 3'd0;
	localparam logic [2:0] KIND_ADD = 3'd1;
	localparam logic [2:0] KIND_SUB = 3'd2;
	localparam logic [2:0] KIND_MUL = 3'd3;
	localparam logic [2:0] KIND_DIV = 3'd4;
	localparam logic [2:0] KIND_END = 3'd5;

	localparam int FLAG_OVERFLOW = 0;
	localparam int FLAG_DIVZERO  = 1;

	typedef struct packed {
		logic [2:0]               kind;
		logic signed [DATA_W-1:0] value;
	} token_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] answer;
		logic [1:0]               status;
	} result_t;

	typedef struct packed {
		logic [2:0]        op;
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] x;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic              divzero;
		logic [DATA_W-1:0] result;
	} alu_rsp_t;

endpackage

// ===== design/rpn_ram.sv =====
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/rpn_alu.sv =====
// ----------------------------------------------------------------------------
// rpn_alu
// Iterative arithmetic unit built round one shared 34-bit adder. Add and
// subtract take one pass; multiply is shift-and-add and divide is restoring
// division on magnitudes, each 32 steps plus a final pass.
// ----------------------------------------------------------------------------
module rpn_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rpn_pkg::alu_req_t req,
	output rpn_pkg::alu_rsp_t rsp
);

	typedef enum logic [2:0] {
		A_IDLE = 3'b001,
		A_RUN  = 3'b010,
		A_FIN  = 3'b100
	} alu_state_t;

	alu_state_t                       state_q;
	logic [2:0]                       op_q;
	logic [rpn_pkg::DATA_W-1:0]       acc_q;
	logic [rpn_pkg::DATA_W-1:0]       opa_q;
	logic [rpn_pkg::DATA_W-1:0]       opb_q;
	logic [rpn_pkg::ITER_W-1:0]       cnt_q;
	logic                             neg_q;
	logic                             dz_q;

	logic [rpn_pkg::DATA_W+1:0]       add_a;
	logic [rpn_pkg::DATA_W+1:0]       add_b;
	logic [rpn_pkg::DATA_W+1:0]       sum;
	logic                             add_sub;
	logic                             qbit;
	logic [rpn_pkg::DATA_W-1:0]       y_mag;
	logic [rpn_pkg::DATA_W-1:0]       x_mag;

	assign y_mag = req.y[rpn_pkg::DATA_W-1] ? (~req.y + 1'b1) : req.y;
	assign x_mag = req.x[rpn_pkg::DATA_W-1] ? (~req.x + 1'b1) : req.x;

	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			A_RUN: begin
				if (op_q == rpn_pkg::KIND_DIV) begin
					// Trial subtraction of the divisor from the shifted remainder.
					add_a   = {1'b0, acc_q, opa_q[rpn_pkg::DATA_W-1]};
					add_b   = {2'b00, opb_q};
					add_sub = 1'b1;
				end else begin
					add_a = {2'b00, acc_q};
					add_b = opb_q[0] ? {2'b00, opa_q} : '0;
				end
			end
			A_FIN: begin
				case (op_q)
					rpn_pkg::KIND_ADD: begin
						add_a = {2'b00, opa_q};
						add_b = {2'b00, opb_q};
					end
					rpn_pkg::KIND_SUB: begin
						add_a   = {2'b00, opa_q};
						add_b   = {2'b00, opb_q};
						add_sub = 1'b1;
					end
					rpn_pkg::KIND_MUL: begin
						add_a = {2'b00, acc_q};
					end
					default: begin
						// Divide: apply the sign to the quotient magnitude.
						add_b   = {2'b00, opa_q};
						add_sub = neg_q;
					end
				endcase
			end
			default: begin
			end
		endcase
		sum = add_a + (add_sub ? ~add_b : add_b) + {{(rpn_pkg::DATA_W+1){1'b0}}, add_sub};
	end

	assign qbit = ~sum[rpn_pkg::DATA_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
		end else begin
			unique case (state_q)
				A_IDLE: begin
					if (start) begin
						if (req.op == rpn_pkg::KIND_MUL ||
						    (req.op == rpn_pkg::KIND_DIV && req.x != '0)) begin
							state_q <= A_RUN;
						end else begin
							state_q <= A_FIN;
						end
					end
				end
				A_RUN: begin
					if (cnt_q == '0) begin
						state_q <= A_FIN;
					end
				end
				A_FIN: begin
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == A_IDLE && start) begin
			op_q  <= req.op;
			cnt_q <= '1;
			acc_q <= '0;
			if (req.op == rpn_pkg::KIND_DIV) begin
				opb_q <= x_mag;
				if (req.x == '0) begin
					opa_q <= '0;
					neg_q <= 1'b0;
					dz_q  <= 1'b1;
				end else begin
					opa_q <= y_mag;
					neg_q <= req.y[rpn_pkg::DATA_W-1] ^ req.x[rpn_pkg::DATA_W-1];
					dz_q  <= 1'b0;
				end
			end else begin
				opa_q <= req.y;
				opb_q <= req.x;
				neg_q <= 1'b0;
				dz_q  <= 1'b0;
			end
		end else if (state_q == A_RUN) begin
			cnt_q <= cnt_q - 1'b1;
			if (op_q == rpn_pkg::KIND_DIV) begin
				acc_q <= qbit ? sum[rpn_pkg::DATA_W-1:0]
				              : {acc_q[rpn_pkg::DATA_W-2:0], opa_q[rpn_pkg::DATA_W-1]};
				opa_q <= {opa_q[rpn_pkg::DATA_W-2:0], qbit};
			end else begin
				acc_q <= sum[rpn_pkg::DATA_W-1:0];
				opa_q <= {opa_q[rpn_pkg::DATA_W-2:0], 1'b0};
				opb_q <= {1'b0, opb_q[rpn_pkg::DATA_W-1:1]};
			end
		end
	end

	assign rsp.done    = (state_q == A_FIN);
	assign rsp.divzero = dz_q;
	assign rsp.result  = sum[rpn_pkg::DATA_W-1:0];

endmodule

// ===== design/rpn_stack_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_core
// Postfix integer evaluator on a RAM-backed stack with an iterative ALU.
// A number word is pushed; an operator pops two words, runs rpn_alu (32 steps
// of its shared adder for multiply and divide, none for a zero divisor) and
// pushes the result; an end word pops the answer into the output register.
// One word is worked on at a time; the result sits in an output register.
// Reset empties the stack and clears the status; the RAM is not cleared.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             token_valid,
	output logic             token_stall,
	input  rpn_pkg::token_t  token,
	output logic             result_valid,
	input  logic             result_stall,
	output rpn_pkg::result_t result
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_RDX  = 7'b0000010,
		ST_RDY  = 7'b0000100,
		ST_GETY = 7'b0001000,
		ST_CALC = 7'b0010000,
		ST_PUSH = 7'b0100000,
		ST_END  = 7'b1000000
	} seq_state_t;

	seq_state_t                     state_q;
	logic [rpn_pkg::CNT_W-1:0]      cnt_q;
	logic [1:0]                     err_q;
	logic                           res_valid_q;
	rpn_pkg::result_t               res_data_q;
	logic [2:0]                     kind_q;
	logic [rpn_pkg::DATA_W-1:0]     res_q;
	logic [rpn_pkg::DATA_W-1:0]     x_q;
	logic                           xe_q;
	logic                           ye_q;

	logic                           have_item;
	logic                           out_free;
	logic                           rd_en;
	logic [rpn_pkg::ADDR_W-1:0]     rd_addr;
	logic [rpn_pkg::DATA_W-1:0]     rd_data;
	logic                           wr_en;
	logic                           alu_start;
	rpn_pkg::alu_req_t              alu_req;
	rpn_pkg::alu_rsp_t              alu_rsp;
	logic [rpn_pkg::DATA_W-1:0]     answer;

	assign have_item = (cnt_q != '0);
	assign out_free  = !res_valid_q || !result_stall;
	assign rd_addr   = rpn_pkg::ADDR_W'(cnt_q - 1'b1);
	assign rd_en     = have_item &&
	                   (state_q == ST_RDX || (state_q == ST_RDY && kind_q != rpn_pkg::KIND_END));
	assign wr_en     = (state_q == ST_PUSH) && (cnt_q < rpn_pkg::DEPTH_CNT);
	assign alu_start = (state_q == ST_GETY);
	assign answer    = xe_q ? '1 : rd_data;

	always_comb begin
		alu_req.op = kind_q;
		alu_req.y  = ye_q ? '1 : rd_data;
		alu_req.x  = x_q;
	end

	rpn_ram #(
		.WIDTH(rpn_pkg::DATA_W),
		.DEPTH(rpn_pkg::STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[rpn_pkg::ADDR_W-1:0]),
		.wr_data (res_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	rpn_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (alu_start),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			err_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_END && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (token_valid) begin
						unique case (token.kind) inside
							rpn_pkg::KIND_NUM: state_q <= ST_PUSH;
							rpn_pkg::KIND_ADD, rpn_pkg::KIND_SUB, rpn_pkg::KIND_MUL,
							rpn_pkg::KIND_DIV, rpn_pkg::KIND_END: state_q <= ST_RDX;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_RDX: begin
					if (have_item) begin
						cnt_q <= cnt_q - 1'b1;
					end
					state_q <= ST_RDY;
				end
				ST_RDY: begin
					if (kind_q == rpn_pkg::KIND_END) begin
						state_q <= ST_END;
					end else begin
						if (have_item) begin
							cnt_q <= cnt_q - 1'b1;
						end
						state_q <= ST_GETY;
					end
				end
				ST_GETY: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (alu_rsp.done) begin
						if (alu_rsp.divzero) begin
							err_q[rpn_pkg::FLAG_DIVZERO] <= 1'b1;
						end
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (cnt_q < rpn_pkg::DEPTH_CNT) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						err_q[rpn_pkg::FLAG_OVERFLOW] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_END: begin
					// The popped word stays on the RAM read port until the slot frees.
					if (out_free) begin
						cnt_q       <= '0;
						err_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && token_valid) begin
			kind_q <= token.kind;
			res_q  <= token.value;
		end
		if (state_q == ST_RDX) begin
			xe_q <= !have_item;
		end
		if (state_q == ST_RDY) begin
			x_q  <= answer;
			ye_q <= !have_item;
		end
		if (state_q == ST_CALC && alu_rsp.done) begin
			res_q <= alu_rsp.result;
		end
		if (state_q == ST_END && out_free) begin
			res_data_q.answer <= answer;
			res_data_q.status <= err_q;
		end
	end

	assign token_stall  = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_data_q;

endmodule

// ===== design/rpn_checker.sv =====
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks of the postfix evaluator, bound to its top level.
// ----------------------------------------------------------------------------
module rpn_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             token_valid,
	input logic             token_stall,
	input rpn_pkg::token_t  token,
	input logic             result_valid,
	input logic             result_stall,
	input rpn_pkg::result_t result
);

	// A held result word must stay offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word withdrawn while stalled");

	// A held result word must not change.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result word changed while stalled");

	// Any meaningful token keeps the block busy for at least the next cycle.
	a_busy_after_token: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_stall && token.kind[2:1] != 2'b11 |=> token_stall)
		else $error("block took no time over an accepted token");

	// A new result is only produced while a token is being worked on.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(token_stall))
		else $error("result appeared without a token in progress");

endmodule

bind rpn_stack_evaluator_core rpn_checker u_rpn_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.token_valid  (token_valid),
	.token_stall  (token_stall),
	.token        (token),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// ===== tb/rpn_answer_checker.sv =====
// ----------------------------------------------------------------------------
// rpn_answer_checker
// Watches both word channels of the postfix evaluator and keeps its own copy
// of the stack and status. Every end-of-expression word queues the expected
// answer, and each result word is compared with the oldest queued answer.
// ----------------------------------------------------------------------------
module rpn_answer_checker
	import rpn_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    token_valid,
	input  logic    token_stall,
	input  token_t  token,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result,
	output int      mismatch_count,
	output int      answers_outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
	int unsigned       stack_fill = 0;
	logic [1:0]        status_acc = '0;
	result_t           answers_due [$];

	// An empty stack gives all ones without touching the store.
	function automatic logic [DATA_W-1:0] stack_pop();
		if (stack_fill == 0)
			return '1;
		stack_fill--;
		return stack_mem[stack_fill];
	endfunction

	function automatic void stack_push(logic [DATA_W-1:0] v);
		if (stack_fill >= STACK_DEPTH) begin
			status_acc[FLAG_OVERFLOW] = 1'b1;
		end else begin
			stack_mem[stack_fill] = v;
			stack_fill++;
		end
	endfunction

	function automatic logic [DATA_W-1:0] quotient_toward_zero(logic [DATA_W-1:0] y,
			logic [DATA_W-1:0] x);
		logic [DATA_W-1:0] mag_y;
		logic [DATA_W-1:0] mag_x;
		logic [DATA_W-1:0] q;
		mag_y = y[DATA_W-1] ? -y : y;
		mag_x = x[DATA_W-1] ? -x : x;
		q = mag_y / mag_x;
		if (y[DATA_W-1] ^ x[DATA_W-1])
			q = -q;
		return q;
	endfunction

	task automatic evaluate_word(token_t t);
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] r;
		result_t           due;
		case (t.kind)
			KIND_NUM: stack_push(t.value);
			KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
				x = stack_pop();
				y = stack_pop();
				case (t.kind)
					KIND_ADD: r = y + x;
					KIND_SUB: r = y - x;
					KIND_MUL: r = y * x;
					default: begin
						if (x == '0) begin
							r = '0;
							status_acc[FLAG_DIVZERO] = 1'b1;
						end else begin
							r = quotient_toward_zero(y, x);
						end
					end
				endcase
				stack_push(r);
			end
			KIND_END: begin
				due.answer = stack_pop();
				due.status = status_acc;
				answers_due.push_back(due);
				stack_fill = 0;
				status_acc = '0;
			end
			default: ;
		endcase
	endtask

	task automatic check_answer(result_t got);
		result_t due;
		if (answers_due.size() == 0) begin
			$display("%0t: unexpected result word, answer %0d status %0d", $time,
				got.answer, got.status);
			mismatch_count++;
		end else begin
			due = answers_due.pop_front();
			if (got.answer !== due.answer) begin
				$display("%0t: answer expected %0d, actual %0d", $time, due.answer,
					got.answer);
				mismatch_count++;
			end
			if (got.status !== due.status) begin
				$display("%0t: status expected %0d, actual %0d", $time, due.status,
					got.status);
				mismatch_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_fill = 0;
			status_acc = '0;
			answers_due.delete();
		end else begin
			// A result cannot stem from a word accepted at the same edge.
			if (result_valid && !result_stall)
				check_answer(result);
			if (token_valid && !token_stall)
				evaluate_word(token);
		end
		answers_outstanding = answers_due.size();
	end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the postfix evaluator with directed and random expressions under
// random sender gaps and receiver stalls, with one long receiver hold-off.
// The checker beside the block predicts and compares every answer.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rpn_pkg::*;

	localparam logic [2:0]        KIND_SPARE_LO = 3'd6;
	localparam logic [2:0]        KIND_SPARE_HI = 3'd7;
	localparam logic [DATA_W-1:0] INT_MIN       = 32'h8000_0000;
	localparam logic [DATA_W-1:0] INT_MAX       = 32'h7fff_ffff;
	localparam int                RANDOM_WORDS  = 900;
	localparam int                HOLD_START    = 3000;
	localparam int                HOLD_CYCLES   = 1500;
	localparam int                DRAIN_CYCLES  = 60;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    token_valid  = 1'b0;
	logic    result_stall = 1'b0;
	token_t  token        = '0;
	logic    token_stall;
	logic    result_valid;
	result_t result;
	int      mismatch_count;
	int      answers_outstanding;
	int      burst_left   = 0;
	int      words_counted = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	rpn_stack_evaluator_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token        (token),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	rpn_answer_checker u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.token_valid         (token_valid),
		.token_stall         (token_stall),
		.token               (token),
		.result_valid        (result_valid),
		.result_stall        (result_stall),
		.result              (result),
		.mismatch_count      (mismatch_count),
		.answers_outstanding (answers_outstanding)
	);

	// Offers one word and returns at the edge where it is taken.
	task automatic send_word(logic [2:0] k, logic [DATA_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				token_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		token_valid <= 1'b1;
		token       <= '{kind: k, value: v};
		do @(posedge clk); while (token_stall);
		if (k != KIND_SPARE_LO && k != KIND_SPARE_HI)
			words_counted++;
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return '0;
					1: return 1;
					2: return '1;
					3: return INT_MIN;
					default: return INT_MAX;
				endcase
			end
			1, 2, 3: return DATA_W'($urandom_range(0, 20) - 10);
			4: return $urandom_range(0, 65535);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [2:0] pick_op();
		case ($urandom_range(0, 3))
			0: return KIND_ADD;
			1: return KIND_SUB;
			2: return KIND_MUL;
			default: return KIND_DIV;
		endcase
	endfunction

	function automatic logic [2:0] pick_spare();
		return $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
	endfunction

	// Well-formed expression that leaves exactly one value before its end word.
	task automatic send_expression(int operands);
		int pushed;
		int depth;
		pushed = 0;
		depth  = 0;
		while (pushed < operands || depth > 1) begin
			if (pushed < operands && (depth < 2 || $urandom_range(0, 1) == 1)) begin
				send_word(KIND_NUM, pick_value());
				pushed++;
				depth++;
			end else begin
				send_word(pick_op(), pick_value());
				depth--;
			end
			if ($urandom_range(0, 19) == 0)
				send_word(pick_spare(), $urandom());
		end
		send_word(KIND_END, $urandom());
	endtask

	// Fills the stack to within two of its depth or past it, then works some of it off.
	task automatic send_overflow();
		int pushes;
		pushes = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 6);
		repeat (pushes) send_word(KIND_NUM, pick_value());
		repeat ($urandom_range(0, pushes + 2)) send_word(pick_op(), pick_value());
		send_word(KIND_END, $urandom());
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 10)) send_word(3'($urandom_range(0, 7)), pick_value());
		if ($urandom_range(0, 1))
			send_word(KIND_END, $urandom());
	endtask

	task automatic send_underflow();
		repeat ($urandom_range(0, 1)) send_word(KIND_NUM, pick_value());
		repeat ($urandom_range(1, 4)) send_word(pick_op(), pick_value());
		send_word(KIND_END, $urandom());
	endtask

	// Receiver: stall rate changes from stretch to stretch, plus one long hold.
	initial begin
		int cycle_no;
		int hold_left;
		int mode_left;
		int stall_pct;
		cycle_no  = 0;
		hold_left = 0;
		mode_left = 0;
		stall_pct = 0;
		forever begin
			@(posedge clk);
			cycle_no++;
			if (cycle_no == HOLD_START)
				hold_left = HOLD_CYCLES;
			if (mode_left == 0) begin
				mode_left = $urandom_range(20, 200);
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 40;
					default: stall_pct = 85;
				endcase
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(1, 100) <= stall_pct);
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// End word and operator on an empty stack.
		send_word(KIND_END, '0);
		send_word(KIND_ADD, '1);
		send_word(KIND_END, INT_MAX);
		// Wrap on add and subtract.
		send_word(KIND_NUM, INT_MAX);
		send_word(KIND_NUM, 1);
		send_word(KIND_ADD, '0);
		send_word(KIND_END, '0);
		send_word(KIND_NUM, INT_MIN);
		send_word(KIND_NUM, 1);
		send_word(KIND_SUB, '0);
		send_word(KIND_END, '0);
		// Most negative value divided by minus one.
		send_word(KIND_NUM, INT_MIN);
		send_word(KIND_NUM, '1);
		send_word(KIND_DIV, '0);
		send_word(KIND_END, '0);
		// Truncation toward zero, a zero divisor and a wrapping product.
		send_word(KIND_NUM, -7);
		send_word(KIND_NUM, 2);
		send_word(KIND_DIV, '0);
		send_word(KIND_NUM, '0);
		send_word(KIND_DIV, '0);
		send_word(KIND_NUM, 32'h0001_0001);
		send_word(KIND_NUM, 32'h0000_ffff);
		send_word(KIND_MUL, '0);
		send_word(KIND_SPARE_LO, INT_MAX);
		send_word(KIND_SPARE_HI, INT_MIN);
		send_word(KIND_END, '0);

		words_counted = 0;
		while (words_counted < RANDOM_WORDS) begin
			case ($urandom_range(0, 99)) inside
				[0:79]:  send_expression(($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 8));
				[80:87]: send_noise();
				[88:91]: send_overflow();
				default: send_underflow();
			endcase
		end
		send_word(KIND_END, $urandom());
		token_valid <= 1'b0;

		do @(negedge clk); while (answers_outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && answers_outstanding == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("tb: errors");
		$finish;
	end

endmodule
